// ===== hw/rtl/mchw_pkg.sv =====
`timescale 1ns / 1ps

package mchw_pkg;

   localparam int DEF_NUM_CHANNELS = 8;
   localparam int DEF_TIME_WIDTH   = 32;

   localparam int CFG_W    = 24;
   localparam int CNT_W    = 8;
   localparam int CH_IDX_W = 3;
   localparam int MASK_W   = 8;
   localparam int PADDR_W  = 4;
   localparam int PDATA_W  = 32;

   localparam logic [CFG_W-1:0] TIMEOUT_RST  = CFG_W'(5000);
   localparam logic [CFG_W-1:0] GRACE_RST    = CFG_W'(10000);
   localparam logic [CFG_W-1:0] INTERVAL_RST = CFG_W'(1000);
   localparam logic [CNT_W-1:0] MAXFAIL_RST  = CNT_W'(3);

   typedef enum logic [1:0] {
      CSR_TIMEOUT  = 2'd0,
      CSR_GRACE    = 2'd1,
      CSR_INTERVAL = 2'd2,
      CSR_MAXFAIL  = 2'd3
   } csr_idx_type;

   typedef enum logic {
      REQ_TICK = 1'b0,
      REQ_FEED = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic [CFG_W-1:0] timeout_ticks;
      logic [CFG_W-1:0] grace_ticks;
      logic [CFG_W-1:0] check_interval_ticks;
      logic [CNT_W-1:0] max_fail_count;
   } cfg_type;

endpackage

// ===== hw/rtl/mchw_req_if.sv =====
`timescale 1ns / 1ps

interface mchw_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [mchw_pkg::CH_IDX_W-1:0] channel;

   modport source (output valid, output req_type, output channel, input ready);
   modport sink   (input valid, input req_type, input channel, output ready);
endinterface

// ===== hw/rtl/mchw_rsp_if.sv =====
`timescale 1ns / 1ps

interface mchw_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        check_done;
   logic [mchw_pkg::MASK_W-1:0] timeout_mask;
   logic [mchw_pkg::MASK_W-1:0] never_fed_mask;
   logic [mchw_pkg::CNT_W-1:0]  fail_count;
   logic                        restart;

   modport source (output valid, output check_done, output timeout_mask,
                   output never_fed_mask, output fail_count, output restart,
                   input ready);
   modport sink   (input valid, input check_done, input timeout_mask,
                   input never_fed_mask, input fail_count, input restart,
                   output ready);
endinterface

// ===== hw/rtl/mchw_csr.sv =====
`timescale 1ns / 1ps

module mchw_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mchw_pkg::PADDR_W-1:0]  paddr,
   input  logic [mchw_pkg::PDATA_W-1:0]  pwdata,
   output logic [mchw_pkg::PDATA_W-1:0]  prdata,
   output logic                          pready,
   output mchw_pkg::cfg_type             cfg
);
   import mchw_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   csr_idx_type idx;
   logic        wr_en;

   assign idx    = csr_idx_type'(paddr[3:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            CSR_TIMEOUT:  cfg_in.timeout_ticks        = pwdata[CFG_W-1:0];
            CSR_GRACE:    cfg_in.grace_ticks          = pwdata[CFG_W-1:0];
            CSR_INTERVAL: cfg_in.check_interval_ticks = pwdata[CFG_W-1:0];
            CSR_MAXFAIL:  cfg_in.max_fail_count       = pwdata[CNT_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks        <= TIMEOUT_RST;
         cfg_ff.grace_ticks          <= GRACE_RST;
         cfg_ff.check_interval_ticks <= INTERVAL_RST;
         cfg_ff.max_fail_count       <= MAXFAIL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         CSR_TIMEOUT:  prdata = PDATA_W'(cfg_ff.timeout_ticks);
         CSR_GRACE:    prdata = PDATA_W'(cfg_ff.grace_ticks);
         CSR_INTERVAL: prdata = PDATA_W'(cfg_ff.check_interval_ticks);
         CSR_MAXFAIL:  prdata = PDATA_W'(cfg_ff.max_fail_count);
         default:      prdata = '0;
      endcase
   end

endmodule

// ===== hw/rtl/mchw_chan.sv =====
`timescale 1ns / 1ps

module mchw_chan #(
   parameter int NUM_CHANNELS = mchw_pkg::DEF_NUM_CHANNELS,
   parameter int TIME_WIDTH   = mchw_pkg::DEF_TIME_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           clear,
   input  logic                           feed_en,
   input  logic [mchw_pkg::CH_IDX_W-1:0]  feed_ch,
   input  logic [TIME_WIDTH-1:0]          feed_time,
   input  logic [TIME_WIDTH-1:0]          now,
   input  mchw_pkg::cfg_type              cfg,
   output logic [NUM_CHANNELS-1:0]        timeout_fail,
   output logic [NUM_CHANNELS-1:0]        never_fed_fail
);
   import mchw_pkg::*;

   localparam int CMP_W = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

   logic [TIME_WIDTH-1:0]   last_feed_ff [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] active_ff;
   logic [NUM_CHANNELS-1:0] active_in;
   logic [NUM_CHANNELS-1:0] hit;
   logic                    grace_over;

   assign grace_over = CMP_W'(now) > CMP_W'(cfg.grace_ticks);

   for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_ch
      logic [TIME_WIDTH-1:0] since;

      assign hit[c]   = feed_en && (32'(feed_ch) == c);
      assign since    = now - last_feed_ff[c];
      assign never_fed_fail[c] = !active_ff[c] && grace_over;
      assign timeout_fail[c]   = active_ff[c] &&
                                 (CMP_W'(since) > CMP_W'(cfg.timeout_ticks));

      always_ff @(posedge clock) begin
         if (hit[c]) begin
            last_feed_ff[c] <= feed_time;
         end
      end
   end

   assign active_in = clear ? '0 : (active_ff | hit);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else begin
         active_ff <= active_in;
      end
   end

endmodule

// ===== hw/rtl/multi_channel_heartbeat_watchdog_core.sv =====
`timescale 1ns / 1ps
// channel  dir  handshake        payload
// req_bus  in   valid/ready      req_type, channel
// rsp_bus  out  valid/ready      check_done, timeout_mask, never_fed_mask,
//                                fail_count, restart
// csr      in   apb (psel etc.)  4 registers at 0x0, 0x4, 0x8, 0xC
//
// One beat per cycle while the result register is not held by rsp_bus.ready.
// A request passes through an input register and then a result register,
// with the channel compares and counter update between them.
// Synchronous active-high reset; no clearing pass, ready right after reset.
// A full result register with rsp_bus.ready low stalls the input register; a request is still taken
// while the input register is empty.

module multi_channel_heartbeat_watchdog_core #(
   parameter int NUM_CHANNELS = mchw_pkg::DEF_NUM_CHANNELS,
   parameter int TIME_WIDTH   = mchw_pkg::DEF_TIME_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   mchw_req_if.sink                      req_bus,
   mchw_rsp_if.source                    rsp_bus,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mchw_pkg::PADDR_W-1:0]  paddr,
   input  logic [mchw_pkg::PDATA_W-1:0]  pwdata,
   output logic [mchw_pkg::PDATA_W-1:0]  prdata,
   output logic                          pready
);
   import mchw_pkg::*;

   cfg_type cfg;

   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_type_ff;
   logic [CH_IDX_W-1:0]     s1_ch_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_done_ff;
   logic [MASK_W-1:0]       rsp_tmask_ff, rsp_nmask_ff;
   logic [CNT_W-1:0]        rsp_count_ff;
   logic                    rsp_restart_ff;

   logic [TIME_WIDTH-1:0]   tick_ff, tick_in, tick_next;
   logic [CFG_W-1:0]        interval_ff, interval_in, interval_next;
   logic [CNT_W-1:0]        fails_ff, fails_in, fails_sat, fails_new;

   logic                    advance, accept, fire, is_tick, check, any_fail, restart;
   logic [CFG_W-1:0]        period;
   logic [NUM_CHANNELS-1:0] tfail, nfail;
   logic [MASK_W+NUM_CHANNELS-1:0] tfail_pad, nfail_pad;

   mchw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mchw_chan #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .TIME_WIDTH   (TIME_WIDTH)
   ) u_chan (
      .clock          (clock),
      .reset          (reset),
      .clear          (fire && restart),
      .feed_en        (fire && !is_tick),
      .feed_ch        (s1_ch_ff),
      .feed_time      (tick_ff),
      .now            (tick_next),
      .cfg            (cfg),
      .timeout_fail   (tfail),
      .never_fed_fail (nfail)
   );

   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !s1_valid_ff || advance;
   assign accept        = req_bus.valid && req_bus.ready;
   assign fire          = s1_valid_ff && advance;

   assign is_tick       = (s1_type_ff == REQ_TICK);
   assign tick_next     = tick_ff + 1'b1;
   assign interval_next = interval_ff + 1'b1;
   assign period        = (cfg.check_interval_ticks == '0) ? CFG_W'(1)
                                                           : cfg.check_interval_ticks;
   assign check         = is_tick && (interval_next >= period);
   assign any_fail      = |(tfail | nfail);
   assign fails_sat     = (fails_ff == '1) ? fails_ff : fails_ff + 1'b1;
   assign fails_new     = check ? (any_fail ? fails_sat : '0) : fails_ff;
   assign restart       = check && any_fail && (fails_sat >= cfg.max_fail_count);

   assign tfail_pad = {MASK_W'(0), tfail};
   assign nfail_pad = {MASK_W'(0), nfail};

   assign s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_comb begin
      tick_in     = tick_ff;
      interval_in = interval_ff;
      fails_in    = fails_ff;
      if (fire) begin
         if (restart) begin
            tick_in     = '0;
            interval_in = '0;
            fails_in    = '0;
         end else if (is_tick) begin
            tick_in     = tick_next;
            interval_in = check ? '0 : interval_next;
            fails_in    = fails_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tick_ff      <= '0;
         interval_ff  <= '0;
         fails_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         tick_ff      <= tick_in;
         interval_ff  <= interval_in;
         fails_ff     <= fails_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_type_ff <= req_bus.req_type;
         s1_ch_ff   <= req_bus.channel;
      end
      if (fire) begin
         rsp_done_ff    <= check;
         rsp_tmask_ff   <= check ? tfail_pad[MASK_W-1:0] : '0;
         rsp_nmask_ff   <= check ? nfail_pad[MASK_W-1:0] : '0;
         rsp_count_ff   <= fails_new;
         rsp_restart_ff <= restart;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.check_done     = rsp_done_ff;
   assign rsp_bus.timeout_mask   = rsp_tmask_ff;
   assign rsp_bus.never_fed_mask = rsp_nmask_ff;
   assign rsp_bus.fail_count     = rsp_count_ff;
   assign rsp_bus.restart        = rsp_restart_ff;

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      fire && restart |=> (tick_ff == '0) && (interval_ff == '0) && (fails_ff == '0))
      else $error("restart did not clear watchdog state");

   a_restart_on_check: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.restart |-> rsp_bus.check_done)
      else $error("restart without check");

   a_feed_no_check: assert property (@(posedge clock) disable iff (reset)
      fire && !is_tick |=> rsp_bus.valid && !rsp_bus.check_done
                           && (rsp_bus.timeout_mask == '0))
      else $error("feed beat produced a check");

   a_feed_keeps_time: assert property (@(posedge clock) disable iff (reset)
      fire && !is_tick |=> (tick_ff == $past(tick_ff)))
      else $error("feed beat advanced time");

endmodule

// ===== verif/multi_channel_heartbeat_watchdog_core_tb.sv =====
`timescale 1ns / 1ps

module multi_channel_heartbeat_watchdog_core_tb;
   import mchw_pkg::*;

   localparam int NCH        = DEF_NUM_CHANNELS;
   localparam int TIME_W     = DEF_TIME_WIDTH;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 80;

   typedef struct packed {
      logic              check_done;
      logic [MASK_W-1:0] timeout_mask;
      logic [MASK_W-1:0] never_fed_mask;
      logic [CNT_W-1:0]  fail_count;
      logic              restart;
   } wd_status_type;

   typedef enum logic {
      ROW_BEAT = 1'b0,
      ROW_CSR  = 1'b1
   } row_kind_type;

   typedef struct {
      row_kind_type         kind;
      csr_idx_type          reg_idx;
      logic [PDATA_W-1:0]   value;
      req_kind_type         req;
      logic [CH_IDX_W-1:0]  ch;
      bit                   typed;
      wd_status_type        res;
   } plan_row_type;

   logic                clock;
   logic                reset;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [PADDR_W-1:0]  paddr;
   logic [PDATA_W-1:0]  pwdata;
   logic [PDATA_W-1:0]  prdata;
   logic                pready;

   mchw_req_if req_bus ();
   mchw_rsp_if rsp_bus ();

   multi_channel_heartbeat_watchdog_core u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // watchdog shadow: config and state
   logic [CFG_W-1:0]  cfg_timeout  = TIMEOUT_RST;
   logic [CFG_W-1:0]  cfg_grace    = GRACE_RST;
   logic [CFG_W-1:0]  cfg_interval = INTERVAL_RST;
   logic [CNT_W-1:0]  cfg_maxfail  = MAXFAIL_RST;
   logic [TIME_W-1:0] tick_now     = '0;
   logic [CFG_W-1:0]  interval_cnt = '0;
   logic [TIME_W-1:0] last_feed [NCH];
   bit                fed [NCH];
   logic [CNT_W-1:0]  fail_run     = '0;

   wd_status_type expected_status [$];
   plan_row_type  plan [$];
   wd_status_type predicted;
   wd_status_type want;
   bit            beat_typed;
   wd_status_type beat_typed_res;
   int         mismatch_count = 0;
   int         cycle_count    = 0;
   int         src_idle_pct;
   int         snk_idle_pct;
   bit         hold_kick      = 1'b0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      for (int c = 0; c < NCH; c++) begin
         last_feed[c] = '0;
         fed[c]       = 1'b0;
      end
   end

   function automatic wd_status_type watchdog_step(req_kind_type kind,
                                                   logic [CH_IDX_W-1:0] ch);
      wd_status_type    r;
      logic [CFG_W-1:0] period;
      logic [TIME_W-1:0] since;
      bit               any_fail;
      bit               fail;
      r = '0;
      if (kind == REQ_FEED) begin
         if (int'(ch) < NCH) begin
            last_feed[ch] = tick_now;
            fed[ch]       = 1'b1;
         end
      end else begin
         period       = (cfg_interval == '0) ? CFG_W'(1) : cfg_interval;
         tick_now     = tick_now + 1'b1;
         interval_cnt = interval_cnt + 1'b1;
         if (interval_cnt >= period) begin
            interval_cnt = '0;
            r.check_done = 1'b1;
            any_fail     = 1'b0;
            for (int c = 0; c < NCH; c++) begin
               if (!fed[c]) begin
                  fail = tick_now > TIME_W'(cfg_grace);
                  if (fail && c < MASK_W) r.never_fed_mask[c] = 1'b1;
               end else begin
                  since = tick_now - last_feed[c];
                  fail  = since > TIME_W'(cfg_timeout);
                  if (fail && c < MASK_W) r.timeout_mask[c] = 1'b1;
               end
               any_fail |= fail;
            end
            if (any_fail) begin
               if (fail_run != '1) fail_run = fail_run + 1'b1;
               if (fail_run >= cfg_maxfail) r.restart = 1'b1;
            end else begin
               fail_run = '0;
            end
         end
      end
      r.fail_count = fail_run;
      if (r.restart) begin
         tick_now     = '0;
         interval_cnt = '0;
         fail_run     = '0;
         for (int c = 0; c < NCH; c++) begin
            last_feed[c] = '0;
            fed[c]       = 1'b0;
         end
      end
      return r;
   endfunction

   function automatic plan_row_type blank_row();
      plan_row_type row;
      row.kind    = ROW_BEAT;
      row.reg_idx = CSR_TIMEOUT;
      row.value   = '0;
      row.req     = REQ_TICK;
      row.ch      = '0;
      row.typed   = 1'b0;
      row.res     = '0;
      return row;
   endfunction

   function automatic void add_csr(csr_idx_type idx, logic [PDATA_W-1:0] value);
      plan_row_type row;
      row         = blank_row();
      row.kind    = ROW_CSR;
      row.reg_idx = idx;
      row.value   = value;
      plan.push_back(row);
   endfunction

   function automatic void add_beat(req_kind_type kind, logic [CH_IDX_W-1:0] ch);
      plan_row_type row;
      row      = blank_row();
      row.kind = ROW_BEAT;
      row.req  = kind;
      row.ch   = ch;
      plan.push_back(row);
   endfunction

   function automatic void add_checked(req_kind_type kind, logic [CH_IDX_W-1:0] ch,
                                       logic done, logic [MASK_W-1:0] tm,
                                       logic [MASK_W-1:0] nm, logic [CNT_W-1:0] fc,
                                       logic rs);
      plan_row_type row;
      row       = blank_row();
      row.kind  = ROW_BEAT;
      row.req   = kind;
      row.ch    = ch;
      row.typed = 1'b1;
      row.res   = {done, tm, nm, fc, rs};
      plan.push_back(row);
   endfunction

   task automatic csr_write(csr_idx_type idx, logic [PDATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_TIMEOUT:  cfg_timeout  = value[CFG_W-1:0];
         CSR_GRACE:    cfg_grace    = value[CFG_W-1:0];
         CSR_INTERVAL: cfg_interval = value[CFG_W-1:0];
         CSR_MAXFAIL:  cfg_maxfail  = value[CNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (expected_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_beat(req_kind_type kind, logic [CH_IDX_W-1:0] ch,
                            bit typed, wd_status_type res);
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.channel  <= ch;
      beat_typed       <= typed;
      beat_typed_res   <= res;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic program_phase(int ph);
      logic [PDATA_W-1:0] junk;
      junk = $urandom() & 32'hFF00_0000;
      case (ph)
         1: begin
            csr_write(CSR_TIMEOUT, 32'd0);
            csr_write(CSR_GRACE, 32'd0);
            csr_write(CSR_INTERVAL, 32'd1);
            csr_write(CSR_MAXFAIL, 32'd255);
         end
         3: begin
            csr_write(CSR_TIMEOUT, 32'h00FF_FFFF | junk);
            csr_write(CSR_GRACE, 32'h00FF_FFFF);
            csr_write(CSR_INTERVAL, 32'd0);
            csr_write(CSR_MAXFAIL, 32'd1 | ($urandom() & 32'hFFFF_FF00));
         end
         default: begin
            csr_write(CSR_TIMEOUT, $urandom_range(12) | junk);
            csr_write(CSR_GRACE, $urandom_range(20) | ($urandom() & 32'hFF00_0000));
            csr_write(CSR_INTERVAL, $urandom_range(4) | ($urandom() & 32'hFF00_0000));
            csr_write(CSR_MAXFAIL, $urandom_range(5) | ($urandom() & 32'hFFFF_FF00));
         end
      endcase
   endtask

   // response side: random backpressure plus one long hold on request
   initial begin
      int hold_left;
      bit hold_seen;
      hold_left = 0;
      hold_seen = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_kick != hold_seen) begin
            hold_seen = hold_kick;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            predicted = watchdog_step(req_kind_type'(req_bus.req_type), req_bus.channel);
            expected_status.push_back(beat_typed ? beat_typed_res : predicted);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_status.size() == 0) begin
               $error("status beat with nothing expected");
               mismatch_count++;
            end else begin
               want = expected_status.pop_front();
               if (rsp_bus.check_done !== want.check_done) begin
                  $error("check_done: expected %0h, got %0h",
                         want.check_done, rsp_bus.check_done);
                  mismatch_count++;
               end
               if (rsp_bus.timeout_mask !== want.timeout_mask) begin
                  $error("timeout_mask: expected %0h, got %0h",
                         want.timeout_mask, rsp_bus.timeout_mask);
                  mismatch_count++;
               end
               if (rsp_bus.never_fed_mask !== want.never_fed_mask) begin
                  $error("never_fed_mask: expected %0h, got %0h",
                         want.never_fed_mask, rsp_bus.never_fed_mask);
                  mismatch_count++;
               end
               if (rsp_bus.fail_count !== want.fail_count) begin
                  $error("fail_count: expected %0d, got %0d",
                         want.fail_count, rsp_bus.fail_count);
                  mismatch_count++;
               end
               if (rsp_bus.restart !== want.restart) begin
                  $error("restart: expected %0h, got %0h",
                         want.restart, rsp_bus.restart);
                  mismatch_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int n_items;
      int tick_pct;
      req_kind_type kind;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.req_type <= REQ_TICK;
      req_bus.channel  <= '0;
      beat_typed       <= 1'b0;
      beat_typed_res   <= '0;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      src_idle_pct = 19;
      snk_idle_pct = 49;

      // defaults out of reset
      add_checked(REQ_FEED, 3'd5, 1'b0, 8'h00, 8'h00, 8'd0, 1'b0);
      add_checked(REQ_TICK, 3'd0, 1'b0, 8'h00, 8'h00, 8'd0, 1'b0);
      // short windows: timeouts, grace expiry, restart at max
      add_csr(CSR_TIMEOUT, 32'd2);
      add_csr(CSR_GRACE, 32'd3);
      add_csr(CSR_INTERVAL, 32'd1);
      add_csr(CSR_MAXFAIL, 32'd3);
      add_checked(REQ_FEED, 3'd0, 1'b0, 8'h00, 8'h00, 8'd0, 1'b0);
      add_checked(REQ_FEED, 3'd7, 1'b0, 8'h00, 8'h00, 8'd0, 1'b0);
      add_checked(REQ_TICK, 3'd7, 1'b1, 8'h00, 8'h00, 8'd0, 1'b0);
      add_beat(REQ_TICK, 3'd0);
      add_beat(REQ_TICK, 3'd3);
      add_checked(REQ_FEED, 3'd0, 1'b0, 8'h00, 8'h00, 8'd2, 1'b0);
      add_checked(REQ_TICK, 3'd0, 1'b1, 8'hA0, 8'h5E, 8'd3, 1'b1);
      add_checked(REQ_TICK, 3'd0, 1'b1, 8'h00, 8'h00, 8'd0, 1'b0);
      // zero interval and zero max: every tick checks, any fail restarts
      add_csr(CSR_TIMEOUT, 32'd0);
      add_csr(CSR_GRACE, 32'd0);
      add_csr(CSR_INTERVAL, 32'd0);
      add_csr(CSR_MAXFAIL, 32'd0);
      add_checked(REQ_TICK, 3'd0, 1'b1, 8'h00, 8'hFF, 8'd1, 1'b1);
      add_checked(REQ_FEED, 3'd3, 1'b0, 8'h00, 8'h00, 8'd0, 1'b0);
      add_beat(REQ_TICK, 3'd4);
      // full-scale registers
      add_csr(CSR_TIMEOUT, 32'h00FF_FFFF);
      add_csr(CSR_GRACE, 32'h00FF_FFFF);
      add_csr(CSR_INTERVAL, 32'h00FF_FFFF);
      add_csr(CSR_MAXFAIL, 32'h0000_00FF);
      add_checked(REQ_TICK, 3'd0, 1'b0, 8'h00, 8'h00, 8'd0, 1'b0);
      add_checked(REQ_FEED, 3'd6, 1'b0, 8'h00, 8'h00, 8'd0, 1'b0);
      add_checked(REQ_TICK, 3'd1, 1'b0, 8'h00, 8'h00, 8'd0, 1'b0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            req_bus.valid <= 1'b0;
            wait_drained();
            csr_write(plan[i].reg_idx, plan[i].value);
         end else begin
            send_beat(plan[i].req, plan[i].ch, plan[i].typed, plan[i].res);
         end
      end

      for (int ph = 0; ph < 6; ph++) begin
         case (ph / 2)
            0: begin src_idle_pct = 19; snk_idle_pct = 49; end
            1: begin src_idle_pct = 49; snk_idle_pct = 19; end
            default: begin src_idle_pct = 0; snk_idle_pct = 0; end
         endcase
         req_bus.valid <= 1'b0;
         wait_drained();
         program_phase(ph);
         n_items  = (ph == 1) ? 300 : (ph == 3) ? 100 : 180;
         tick_pct = (ph == 1) ? 95 : 60;
         for (int i = 0; i < n_items; i++) begin
            if (ph == 4 && i == 20) hold_kick = ~hold_kick;
            if (ph == 2 && i == 90) begin
               req_bus.valid <= 1'b0;
               wait_drained();
            end
            kind = ($urandom_range(99) < tick_pct) ? REQ_TICK : REQ_FEED;
            send_beat(kind, CH_IDX_W'($urandom_range(NCH - 1)), 1'b0, '0);
         end
      end

      req_bus.valid <= 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/mchw_pkg.sv
hw/rtl/mchw_req_if.sv
hw/rtl/mchw_rsp_if.sv
hw/rtl/mchw_csr.sv
hw/rtl/mchw_chan.sv
hw/rtl/multi_channel_heartbeat_watchdog_core.sv
verif/multi_channel_heartbeat_watchdog_core_tb.sv
